// ===== sv/wcfc_pkg.sv =====
// Shared types, constants and codes for the coarse/fine wiper calibration core.
// No dependencies; every other file in this folder imports this package.
`timescale 1ns / 1ps

package wcfc_pkg;

  // Wiper positions the search covers, and derived widths.
  localparam int unsigned POSITION_COUNT = 256;
  localparam int unsigned POS_CLOG = $clog2(POSITION_COUNT);
  localparam int unsigned PROBE_W = (POS_CLOG > 9) ? POS_CLOG : 9;

  localparam logic [PROBE_W-1:0] LAST_POSITION = PROBE_W'(POSITION_COUNT - 1);
  localparam logic [PROBE_W:0]   POSITION_LIMIT = (PROBE_W + 1)'(POSITION_COUNT);

  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned WIPER_W  = 8;
  localparam int unsigned STEP_W   = 7;
  localparam int unsigned DIST_W   = 11;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [WIPER_W-1:0]  WIPER_MAX      = 8'd255;
  localparam logic [WIPER_W-1:0]  START_POSITION = 8'd128;
  localparam logic [DIST_W-1:0]   DIST_NONE      = 11'd2047;
  localparam logic [SAMPLE_W-1:0] ERROR_MAX      = 10'd1023;

  localparam logic [SAMPLE_W-1:0] TARGET_RESET = 10'd512;
  localparam logic [STEP_W-1:0]   STEP_RESET   = 7'd4;
  localparam logic [STEP_W-1:0]   RADIUS_RESET = 7'd4;

  typedef enum logic {
    OP_START  = 1'b0,
    OP_SAMPLE = 1'b1
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET = 2'd0,
    CFG_STEP   = 2'd1,
    CFG_RADIUS = 2'd2,
    CFG_NONE   = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_COARSE = 3'b010,
    PH_FINE   = 3'b100
  } phase_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] target_code;
    logic [STEP_W-1:0]   coarse_step;
    logic [STEP_W-1:0]   fine_radius;
  } cfg_t;

  typedef struct packed {
    phase_e             phase;
    logic [PROBE_W-1:0] probe_position;
    logic [PROBE_W-1:0] fine_end;
    logic [WIPER_W-1:0] best_position;
    logic [DIST_W-1:0]  best_distance;
  } state_t;

  typedef struct packed {
    opcode_e             opcode;
    logic [SAMPLE_W-1:0] adc_sample;
  } req_t;

  typedef struct packed {
    logic [WIPER_W-1:0]  wiper_position;
    logic                busy_res;
    logic                done_res;
    logic [SAMPLE_W-1:0] best_error;
  } rsp_t;

  // Saturate a probe position to the wiper command range.
  function automatic logic [WIPER_W-1:0] sat_wiper(input logic [PROBE_W-1:0] p);
    sat_wiper = (p > PROBE_W'(WIPER_MAX)) ? WIPER_MAX : p[WIPER_W-1:0];
  endfunction

endpackage

// ===== sv/wcfc_cfg_regs.sv =====
// Configuration register file: target code, coarse step and fine radius.
// Depends on wcfc_pkg.
`timescale 1ns / 1ps

module wcfc_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [wcfc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [wcfc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output wcfc_pkg::cfg_t                   cfg_o
);
  import wcfc_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_TARGET: cfg_d.target_code = cfg_data_i[SAMPLE_W-1:0];
        CFG_STEP:   cfg_d.coarse_step = cfg_data_i[STEP_W-1:0];
        CFG_RADIUS: cfg_d.fine_radius = cfg_data_i[STEP_W-1:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_code <= TARGET_RESET;
      cfg_q.coarse_step <= STEP_RESET;
      cfg_q.fine_radius <= RADIUS_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== sv/wcfc_step.sv =====
// Single-pass search step: distance, best update, probe advance, result.
// Purely combinational; depends on wcfc_pkg.
`timescale 1ns / 1ps

module wcfc_step (
  input  wcfc_pkg::cfg_t   cfg_i,
  input  wcfc_pkg::state_t state_i,
  input  wcfc_pkg::req_t   req_i,
  output wcfc_pkg::state_t state_o,
  output wcfc_pkg::rsp_t   rsp_o
);
  import wcfc_pkg::*;

  logic [SAMPLE_W-1:0] distance;
  logic                better;
  logic [WIPER_W-1:0]  best_pos_n;
  logic [DIST_W-1:0]   best_dist_n;
  logic [STEP_W-1:0]   step;
  logic [PROBE_W:0]    next_coarse;
  logic [PROBE_W-1:0]  win_lo;
  logic [PROBE_W:0]    win_hi_raw;
  logic [PROBE_W-1:0]  win_hi;
  logic [PROBE_W-1:0]  next_fine;

  // Distance and best update shared by both passes.
  always_comb begin
    distance = (req_i.adc_sample >= cfg_i.target_code) ?
               (req_i.adc_sample - cfg_i.target_code) :
               (cfg_i.target_code - req_i.adc_sample);
    better      = {1'b0, distance} < state_i.best_distance;
    best_pos_n  = better ? sat_wiper(state_i.probe_position) : state_i.best_position;
    best_dist_n = better ? {1'b0, distance} : state_i.best_distance;
  end

  // Coarse advance and fine window around the updated best.
  always_comb begin
    step        = (cfg_i.coarse_step == '0) ? STEP_W'(1) : cfg_i.coarse_step;
    next_coarse = {1'b0, state_i.probe_position} + (PROBE_W + 1)'(step);
    win_lo      = (best_pos_n > WIPER_W'(cfg_i.fine_radius)) ?
                  PROBE_W'(best_pos_n - WIPER_W'(cfg_i.fine_radius)) : '0;
    win_hi_raw  = (PROBE_W + 1)'(best_pos_n) + (PROBE_W + 1)'(cfg_i.fine_radius);
    win_hi      = (win_hi_raw > {1'b0, LAST_POSITION}) ? LAST_POSITION :
                  win_hi_raw[PROBE_W-1:0];
    next_fine   = state_i.probe_position + PROBE_W'(1);
  end

  always_comb begin
    state_o = state_i;
    rsp_o.wiper_position = state_i.best_position;
    rsp_o.busy_res       = 1'b0;
    rsp_o.done_res       = 1'b0;

    if (req_i.opcode == OP_START) begin
      state_o.phase          = PH_COARSE;
      state_o.probe_position = '0;
      state_o.fine_end       = '0;
      state_o.best_position  = START_POSITION;
      state_o.best_distance  = DIST_NONE;
      rsp_o.wiper_position   = '0;
      rsp_o.busy_res         = 1'b1;
    end else begin
      case (state_i.phase)
        PH_COARSE: begin
          state_o.best_position = best_pos_n;
          state_o.best_distance = best_dist_n;
          if (next_coarse < POSITION_LIMIT) begin
            state_o.probe_position = next_coarse[PROBE_W-1:0];
          end else begin
            state_o.probe_position = win_lo;
            state_o.fine_end       = win_hi;
            state_o.phase          = PH_FINE;
          end
          rsp_o.wiper_position = sat_wiper(state_o.probe_position);
          rsp_o.busy_res       = 1'b1;
        end
        PH_FINE: begin
          state_o.best_position = best_pos_n;
          state_o.best_distance = best_dist_n;
          if (state_i.probe_position < state_i.fine_end) begin
            state_o.probe_position = next_fine;
            rsp_o.wiper_position   = sat_wiper(next_fine);
            rsp_o.busy_res         = 1'b1;
          end else begin
            state_o.phase        = PH_IDLE;
            rsp_o.wiper_position = best_pos_n;
            rsp_o.done_res       = 1'b1;
          end
        end
        default: begin
          state_o = state_i;
        end
      endcase
    end

    rsp_o.best_error = state_o.best_distance[DIST_W-1] ? ERROR_MAX :
                       state_o.best_distance[SAMPLE_W-1:0];
  end

endmodule

// ===== sv/wiper_coarse_fine_calibration_core.sv =====
// Coarse/fine wiper calibration core: request register, search step, result register.
// Requests go request register -> search step -> result register; 1 request/cycle unless
// out_stall_i holds it, set by the search step that updates the state on every request.
// The request register doubles as a skid stage while a result waits downstream.
// Reset (async, active low): idle, best position 128, no distance seen, default config.
`timescale 1ns / 1ps

module wiper_coarse_fine_calibration_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // request channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             opcode_i,
  input  logic [wcfc_pkg::SAMPLE_W-1:0]    adc_sample_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [wcfc_pkg::WIPER_W-1:0]     wiper_position_o,
  output logic                             busy_res_o,
  output logic                             done_res_o,
  output logic [wcfc_pkg::SAMPLE_W-1:0]    best_error_o,
  // configuration write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [wcfc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [wcfc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import wcfc_pkg::*;

  cfg_t   cfg;
  state_t state_q, state_d;
  req_t   req_q;
  rsp_t   rsp_q, rsp_d;
  logic   req_vld_q;
  logic   rsp_vld_q;
  logic   advance;
  logic   take_req;

  wcfc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  wcfc_step u_step (
    .cfg_i   (cfg),
    .state_i (state_q),
    .req_i   (req_q),
    .state_o (state_d),
    .rsp_o   (rsp_d)
  );

  // Advance the held request into the result register when that slot frees up.
  assign advance    = req_vld_q && (!rsp_vld_q || !out_stall_i);
  // Hold off new requests only while the request register is full and cannot drain.
  assign in_stall_o = req_vld_q && !advance;
  assign take_req   = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
      rsp_vld_q <= 1'b0;
      state_q.phase          <= PH_IDLE;
      state_q.probe_position <= '0;
      state_q.fine_end       <= '0;
      state_q.best_position  <= START_POSITION;
      state_q.best_distance  <= DIST_NONE;
    end else begin
      if (take_req) begin
        req_vld_q <= 1'b1;
      end else if (advance) begin
        req_vld_q <= 1'b0;
      end
      if (advance) begin
        rsp_vld_q <= 1'b1;
        state_q   <= state_d;
      end else if (!out_stall_i) begin
        rsp_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    if (take_req) begin
      req_q.opcode     <= opcode_e'(opcode_i);
      req_q.adc_sample <= adc_sample_i;
    end
    if (advance) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o      = rsp_vld_q;
  assign wiper_position_o = rsp_q.wiper_position;
  assign busy_res_o       = rsp_q.busy_res;
  assign done_res_o       = rsp_q.done_res;
  assign best_error_o     = rsp_q.best_error;

endmodule
